[rtl/plic_pkg.sv]
package plic_pkg;

    localparam int FRACTION_BITS = 15;
    localparam int GEOM_BITS     = 30;
    localparam int GRAD_W        = 18;
    localparam int SIZE_W        = 31;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [GEOM_BITS:0] GEOM_ONE = {1'b1, {GEOM_BITS{1'b0}}};
    localparam logic [SIZE_W-1:0]  CELL_SIZE_RESET = SIZE_W'(65536);

    typedef struct packed {
        logic        [15:0] f_sw;
        logic        [15:0] f_w;
        logic        [15:0] f_nw;
        logic        [15:0] f_s;
        logic        [15:0] f_center;
        logic        [15:0] f_n;
        logic        [15:0] f_se;
        logic        [15:0] f_e;
        logic        [15:0] f_ne;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
    } t_cell_in;

    typedef struct packed {
        logic               mixed;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } t_seg_out;

    // classified request handed from the front end to the back end
    typedef struct packed {
        logic                  mixed;
        logic                  invx;
        logic                  invz;
        logic                  xgt;
        logic                  unit;
        logic [GRAD_W-1:0]     lesser;
        logic [GRAD_W-1:0]     big;
        logic [GEOM_BITS-1:0]  f;
        logic signed [31:0]    origin_x;
        logic signed [31:0]    origin_y;
    } t_front;

endpackage

[rtl/plic_div.sv]
module plic_div #(
    parameter int DW = 18,
    parameter int QW = 30,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_side
);

    // one quotient bit per stage, numerator below denominator
    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [PW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [PW-1:0] side_in;
        logic [DW:0]   two;
        logic [DW:0]   diff;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        assign two  = {rem_in, 1'b0};
        assign diff = two - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
            r_rem[k]  <= diff[DW] ? two[DW-1:0] : diff[DW-1:0];
            r_den[k]  <= den_in;
            r_quo[k]  <= {quo_in[QW-2:0], ~diff[DW]};
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[rtl/plic_sqrt.sv]
module plic_sqrt #(
    parameter int VW = 62,
    parameter int PW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [VW-1:0]     i_val,
    input  logic [PW-1:0]     i_side,
    output logic              o_valid,
    output logic [VW/2-1:0]   o_root,
    output logic [PW-1:0]     o_side
);

    localparam int RW = VW / 2;

    // digit-by-digit floor root, two radicand bits per stage
    logic          r_vld  [RW];
    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [VW-1:0] r_val  [RW];
    logic [PW-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          v_in;
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [VW-1:0] val_in;
        logic [PW-1:0] side_in;
        logic [RW+3:0] trial_rem;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = i_val;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign val_in  = r_val[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial_rem = {rem_in, val_in[VW-1 -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign ge        = trial_rem >= trial;
        assign diff      = trial_rem - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
            r_rem[k]  <= ge ? diff[RW+1:0] : trial_rem[RW+1:0];
            r_root[k] <= {root_in[RW-2:0], ge};
            r_val[k]  <= {val_in[VW-3:0], 2'b00};
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

[rtl/plic_front.sv]
module plic_front import plic_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_cell_in i_cell,
    output logic     o_push,
    output t_front   o_cls
);

    logic     r_vld;
    t_cell_in r_cell;

    logic [GRAD_W-1:0] sum_w;
    logic [GRAD_W-1:0] sum_e;
    logic [GRAD_W-1:0] sum_s;
    logic [GRAD_W-1:0] sum_n;
    logic [GRAD_W:0]   diff_x;
    logic [GRAD_W:0]   diff_z;
    logic [GRAD_W:0]   neg_x;
    logic [GRAD_W:0]   neg_z;
    logic [GRAD_W-1:0] abs_x;
    logic [GRAD_W-1:0] abs_z;
    logic              xgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
        if (i_accept) begin
            r_cell <= i_cell;
        end
    end

    always_comb begin
        sum_w  = GRAD_W'(r_cell.f_sw) + (GRAD_W'(r_cell.f_w) << 1) + GRAD_W'(r_cell.f_nw);
        sum_e  = GRAD_W'(r_cell.f_se) + (GRAD_W'(r_cell.f_e) << 1) + GRAD_W'(r_cell.f_ne);
        sum_s  = GRAD_W'(r_cell.f_sw) + (GRAD_W'(r_cell.f_s) << 1) + GRAD_W'(r_cell.f_se);
        sum_n  = GRAD_W'(r_cell.f_nw) + (GRAD_W'(r_cell.f_n) << 1) + GRAD_W'(r_cell.f_ne);
        diff_x = {1'b0, sum_w} - {1'b0, sum_e};
        diff_z = {1'b0, sum_s} - {1'b0, sum_n};
        neg_x  = -diff_x;
        neg_z  = -diff_z;
        abs_x  = diff_x[GRAD_W] ? neg_x[GRAD_W-1:0] : diff_x[GRAD_W-1:0];
        abs_z  = diff_z[GRAD_W] ? neg_z[GRAD_W-1:0] : diff_z[GRAD_W-1:0];
        xgt    = abs_x > abs_z;

        o_cls.mixed    = (r_cell.f_center != '0)
                         && (r_cell.f_center < 16'(1 << FRACTION_BITS));
        o_cls.invx     = diff_x[GRAD_W];
        o_cls.invz     = diff_z[GRAD_W];
        o_cls.xgt      = xgt;
        o_cls.big      = xgt ? abs_x : abs_z;
        o_cls.lesser   = xgt ? abs_z : abs_x;
        // zero gradient or equal components: both normal parts are 1.0
        o_cls.unit     = (o_cls.big == '0) || (abs_x == abs_z);
        o_cls.f        = GEOM_BITS'(r_cell.f_center) << (GEOM_BITS - FRACTION_BITS);
        o_cls.origin_x = r_cell.origin_x;
        o_cls.origin_y = r_cell.origin_y;
    end

    assign o_push = r_vld;

endmodule

[rtl/plic_fifo.sv]
module plic_fifo import plic_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_front i_data,
    output logic   o_valid,
    output t_front o_data,
    output logic   o_full_soon
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_front        r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wptr;
    logic [AW-1:0] n_rptr;
    logic [CW-1:0] n_count;
    logic          pop;

    // the back end never stalls, so anything held is taken at once
    assign pop = r_count != '0;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid     = pop;
    assign o_data      = r_mem[r_rptr];
    assign o_full_soon = r_count >= CW'(DEPTH - 1);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'(DEPTH) |-> !i_push)
        else $error("queue written while full");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_push) && $past(r_count) != '0
        |-> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on a pop");

endmodule

[rtl/plic_back.sv]
module plic_back import plic_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_front            i_cls,
    input  logic [SIZE_W-1:0] i_cell_width,
    input  logic [SIZE_W-1:0] i_cell_height,
    output logic              o_valid,
    output t_seg_out          o_seg
);

    localparam logic [1:0] CASE_CORNER = 2'd0;
    localparam logic [1:0] CASE_TRAP   = 2'd1;
    localparam logic [1:0] CASE_COMPL  = 2'd2;

    localparam int GW  = GEOM_BITS + 1;
    localparam int VW  = 2 * GW;
    localparam int MW  = SIZE_W + GW;
    localparam int OW  = MW + 1 - GEOM_BITS;

    typedef struct packed {
        logic                 mixed;
        logic                 invx;
        logic                 invz;
        logic                 xgt;
        logic [1:0]           ccase;
        logic [GEOM_BITS-1:0] f;
        logic [GW-1:0]        nsmall;
        logic signed [31:0]   origin_x;
        logic signed [31:0]   origin_y;
    } t_ctx;

    typedef struct packed {
        t_ctx          ctx;
        logic [GW-1:0] alpha;
        logic          sat;
    } t_quo_side;

    function automatic logic [GW-1:0] clamp_unit(input logic signed [GW:0] t);
        if (t < 0) begin
            return '0;
        end
        if (t > $signed({1'b0, GEOM_ONE})) begin
            return GEOM_ONE;
        end
        return t[GW-1:0];
    endfunction

    function automatic logic signed [31:0] place(input logic signed [31:0] org,
                                                  input logic [MW-1:0] prod);
        logic [MW:0]        rnd;
        logic [OW-1:0]      off;
        logic signed [OW:0] s;
        rnd = {1'b0, prod} + ((MW + 1)'(1) << (GEOM_BITS - 1));
        off = rnd[MW:GEOM_BITS];
        s   = $signed({{(OW + 1 - 32){org[31]}}, org}) + $signed({1'b0, off});
        if (s > $signed((OW + 1)'(32'h7fff_ffff))) begin
            return 32'sh7fff_ffff;
        end
        if (s < -$signed((OW + 1)'(33'h0_8000_0000))) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // normal: smaller component over larger one
    logic                 d1_vld;
    logic [GEOM_BITS-1:0] d1_quo;
    t_front               d1_fr;

    plic_div #(
        .DW (GRAD_W),
        .QW (GEOM_BITS),
        .PW ($bits(t_front))
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   (i_cls.unit ? GRAD_W'(0) : i_cls.lesser),
        .i_den   (i_cls.unit ? GRAD_W'(1) : i_cls.big),
        .i_side  (i_cls),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_fr)
    );

    // case selection and root operand
    logic [GW-1:0] nsmall_b;
    logic [GW-1:0] v1_b;
    logic [GW-1:0] v2_b;
    logic [GW-1:0] f_b;
    logic [1:0]    case_b;
    t_ctx          ctx_b;

    logic          r_b_vld;
    t_ctx          r_b_ctx;
    logic [GW-1:0] r_b_opd;

    always_comb begin
        nsmall_b = d1_fr.unit ? GEOM_ONE : {1'b0, d1_quo};
        v1_b     = nsmall_b >> 1;
        v2_b     = GEOM_ONE - v1_b;
        f_b      = {1'b0, d1_fr.f};
        if (f_b < v1_b) begin
            case_b = CASE_CORNER;
        end else if (f_b < v2_b) begin
            case_b = CASE_TRAP;
        end else begin
            case_b = CASE_COMPL;
        end
        ctx_b.mixed    = d1_fr.mixed;
        ctx_b.invx     = d1_fr.invx;
        ctx_b.invz     = d1_fr.invz;
        ctx_b.xgt      = d1_fr.xgt;
        ctx_b.ccase    = case_b;
        ctx_b.f        = d1_fr.f;
        ctx_b.nsmall   = nsmall_b;
        ctx_b.origin_x = d1_fr.origin_x;
        ctx_b.origin_y = d1_fr.origin_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= d1_vld;
        end
        r_b_ctx <= ctx_b;
        r_b_opd <= (case_b == CASE_CORNER) ? f_b : GEOM_ONE - f_b;
    end

    // radicand f, or 1 - f outside the corner case, times min component (times two below)
    logic          r_c_vld;
    t_ctx          r_c_ctx;
    logic [VW-1:0] r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_ctx  <= r_b_ctx;
        r_c_prod <= r_b_opd * r_b_ctx.nsmall;
    end

    logic          sq_vld;
    logic [GW-1:0] sq_root;
    t_ctx          sq_ctx;

    plic_sqrt #(
        .VW (VW),
        .PW ($bits(t_ctx))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_vld),
        .i_val   ({r_c_prod[VW-2:0], 1'b0}),
        .i_side  (r_c_ctx),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_ctx)
    );

    // alpha over the small component; at or above it the result clamps to 1.0,
    // a zero alpha always gives zero, even over a zero component
    logic          r_d_vld;
    logic [GW-1:0] r_d_num;
    logic [GW-1:0] r_d_den;
    t_quo_side     r_d_side;
    logic          sat_d;

    assign sat_d = (sq_root != '0) && (sq_root >= sq_ctx.nsmall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= sq_vld;
        end
        r_d_num        <= sat_d ? '0 : sq_root;
        r_d_den        <= (sq_ctx.nsmall == '0) ? GW'(1) : sq_ctx.nsmall;
        r_d_side.ctx   <= sq_ctx;
        r_d_side.alpha <= sq_root;
        r_d_side.sat   <= sat_d;
    end

    logic                 d2_vld;
    logic [GEOM_BITS-1:0] d2_quo;
    t_quo_side            d2_side;

    plic_div #(
        .DW (GW),
        .QW (GEOM_BITS),
        .PW ($bits(t_quo_side))
    ) u_div_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_vld),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .i_side  (r_d_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // end points in the unit cell, then unfolded
    logic [GW-1:0]        qs_e;
    logic [GW-1:0]        qo_e;
    logic [GW-1:0]        qx_e;
    logic [GW-1:0]        qz_e;
    logic [GW-1:0]        at_e;
    logic signed [GW:0]   atm_e;
    logic [GW-1:0]        atc_e;
    logic [GW-1:0]        atmc_e;
    logic [GW-1:0]        x1_e;
    logic [GW-1:0]        z1_e;
    logic [GW-1:0]        x2_e;
    logic [GW-1:0]        z2_e;
    t_ctx                 ce;

    logic                 r_e_vld;
    logic                 r_e_mixed;
    logic signed [31:0]   r_e_ox;
    logic signed [31:0]   r_e_oy;
    logic [GW-1:0]        r_e_x1;
    logic [GW-1:0]        r_e_z1;
    logic [GW-1:0]        r_e_x2;
    logic [GW-1:0]        r_e_z2;

    always_comb begin
        ce     = d2_side.ctx;
        qs_e   = d2_side.sat ? GEOM_ONE : {1'b0, d2_quo};
        qo_e   = (d2_side.alpha > GEOM_ONE) ? GEOM_ONE : d2_side.alpha;
        qx_e   = ce.xgt ? qo_e : qs_e;
        qz_e   = ce.xgt ? qs_e : qo_e;
        at_e   = {1'b0, ce.f} + (ce.nsmall >> 1);
        atm_e  = $signed({1'b0, at_e}) - $signed({1'b0, ce.nsmall});
        atc_e  = clamp_unit($signed({1'b0, at_e}));
        atmc_e = clamp_unit(atm_e);
        case (ce.ccase)
            CASE_CORNER: begin
                x1_e = qx_e;
                z1_e = '0;
                x2_e = '0;
                z2_e = qz_e;
            end
            CASE_TRAP: begin
                if (ce.xgt) begin
                    x1_e = atc_e;
                    x2_e = atmc_e;
                    z1_e = '0;
                    z2_e = GEOM_ONE;
                end else begin
                    x1_e = '0;
                    x2_e = GEOM_ONE;
                    z1_e = atc_e;
                    z2_e = atmc_e;
                end
            end
            CASE_COMPL: begin
                x1_e = GEOM_ONE - qx_e;
                z1_e = GEOM_ONE;
                x2_e = GEOM_ONE;
                z2_e = GEOM_ONE - qz_e;
            end
            default: begin
                x1_e = '0;
                z1_e = '0;
                x2_e = '0;
                z2_e = '0;
            end
        endcase
        if (ce.invx) begin
            x1_e = GEOM_ONE - x1_e;
            x2_e = GEOM_ONE - x2_e;
        end
        if (ce.invz) begin
            z1_e = GEOM_ONE - z1_e;
            z2_e = GEOM_ONE - z2_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= d2_vld;
        end
        r_e_mixed <= ce.mixed;
        r_e_ox    <= ce.origin_x;
        r_e_oy    <= ce.origin_y;
        r_e_x1    <= x1_e;
        r_e_z1    <= z1_e;
        r_e_x2    <= x2_e;
        r_e_z2    <= z2_e;
    end

    // scale by cell size
    logic               r_f_vld;
    logic               r_f_mixed;
    logic signed [31:0] r_f_ox;
    logic signed [31:0] r_f_oy;
    logic [MW-1:0]      r_f_px1;
    logic [MW-1:0]      r_f_pz1;
    logic [MW-1:0]      r_f_px2;
    logic [MW-1:0]      r_f_pz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
        r_f_mixed <= r_e_mixed;
        r_f_ox    <= r_e_ox;
        r_f_oy    <= r_e_oy;
        r_f_px1   <= i_cell_width * r_e_x1;
        r_f_pz1   <= i_cell_height * r_e_z1;
        r_f_px2   <= i_cell_width * r_e_x2;
        r_f_pz2   <= i_cell_height * r_e_z2;
    end

    // round, add origin, saturate; all zero for a cell that is not mixed
    logic     r_g_vld;
    t_seg_out r_g_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
        r_g_seg.mixed <= r_f_mixed;
        if (r_f_mixed) begin
            r_g_seg.start_x <= place(r_f_ox, r_f_px1);
            r_g_seg.start_y <= place(r_f_oy, r_f_pz1);
            r_g_seg.end_x   <= place(r_f_ox, r_f_px2);
            r_g_seg.end_y   <= place(r_f_oy, r_f_pz2);
        end else begin
            r_g_seg.start_x <= '0;
            r_g_seg.start_y <= '0;
            r_g_seg.end_x   <= '0;
            r_g_seg.end_y   <= '0;
        end
    end

    assign o_valid = r_g_vld;
    assign o_seg   = r_g_seg;

endmodule

[rtl/plic_interface_segment_top.sv]
// Youngs interface segment for one volume-of-fluid cell. A request carries the 3x3
// fraction stencil and the cell origin; exactly one result comes back per request,
// with o_done high for that single cycle. One request is taken every clock while busy
// is low; the back end is a chain of bit-per-stage units (30-stage normal divider,
// 31-stage square root, 30-stage line divider), all fully pipelined. The receiver
// cannot stall, so results must be taken as they appear. The user must write the
// cell size registers through the cfg port only while idle; the block itself does
// not enforce it.
module plic_interface_segment_top import plic_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cell_in          i_cell,
    output logic              o_done,
    output t_seg_out          o_seg,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam logic [0:0] REG_CELL_WIDTH  = 1'b0;
    localparam logic [0:0] REG_CELL_HEIGHT = 1'b1;

    logic [SIZE_W-1:0] r_cell_width;
    logic [SIZE_W-1:0] r_cell_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= CELL_SIZE_RESET;
            r_cell_height <= CELL_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CELL_WIDTH:  r_cell_width  <= i_cfg_data;
                REG_CELL_HEIGHT: r_cell_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic   accept;
    logic   push;
    t_front cls;
    logic   q_valid;
    t_front q_data;
    logic   q_full_soon;

    assign accept = start && !busy;
    assign busy   = q_full_soon;

    plic_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cell   (i_cell),
        .o_push   (push),
        .o_cls    (cls)
    );

    plic_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (cls),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_full_soon (q_full_soon)
    );

    plic_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_cls         (q_data),
        .i_cell_width  (r_cell_width),
        .i_cell_height (r_cell_height),
        .o_valid       (o_done),
        .o_seg         (o_seg)
    );

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("request queue backed up");

    a_clean_unmixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_seg.mixed |-> o_seg.start_x == 0 && o_seg.start_y == 0
                                   && o_seg.end_x == 0 && o_seg.end_y == 0)
        else $error("segment reported for a cell that is not mixed");

endmodule

[tb/plic_interface_segment_top_tb.sv]
`timescale 1ns / 1ps

module plic_interface_segment_top_tb;
    import plic_pkg::*;

    typedef enum logic [0:0] {
        REG_CELL_WIDTH  = 1'b0,
        REG_CELL_HEIGHT = 1'b1
    } t_cell_reg;

    localparam longint ONE_Q30   = longint'(1) << 30;
    localparam longint QUOT_MAX  = longint'(1) << 33;
    localparam longint NUM_MAX   = longint'(1) << 32;
    localparam int     FRAC_ONE  = 1 << FRACTION_BITS;
    localparam int     SETTLE    = 120;
    localparam int     STALL_MAX = 5000;
    localparam int     N_RANDOM  = 750;

    class segment_scoreboard;
        t_seg_out    pending[$];
        logic [30:0] width_q16;
        logic [30:0] height_q16;
        int          errors;

        function new();
            width_q16  = 31'd65536;
            height_q16 = 31'd65536;
            errors     = 0;
        endfunction

        function void set_reg(t_cell_reg idx, logic [30:0] val);
            if (idx == REG_CELL_WIDTH) begin
                width_q16 = val;
            end else begin
                height_q16 = val;
            end
        endfunction

        function longint root_floor(longint val);
            bit [63:0] rem;
            bit [63:0] res;
            bit [63:0] b;
            rem = val;
            res = 0;
            b   = 64'd1 << 62;
            while (b > rem) b = b >> 2;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return longint'(res);
        endfunction

        // saturating Q.30 divide, truncating toward zero
        function longint sat_div(longint num, longint den);
            logic   neg;
            longint mag;
            longint q;
            neg = num < 0;
            mag = neg ? -num : num;
            if (den <= 0) return (mag == 0) ? 0 : (neg ? -QUOT_MAX : QUOT_MAX);
            if (mag > NUM_MAX) mag = NUM_MAX;
            q = (mag << 30) / den;
            if (q > QUOT_MAX) q = QUOT_MAX;
            return neg ? -q : q;
        endfunction

        function longint unit_clamp(longint t);
            if (t < 0) return 0;
            if (t > ONE_Q30) return ONE_Q30;
            return t;
        endfunction

        function logic [31:0] to_coord(longint origin, logic [30:0] size, longint t);
            longint s;
            s = origin + ((longint'(size) * t + (longint'(1) << 29)) >>> 30);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s[31:0];
        endfunction

        function t_seg_out segment_of(t_cell_in c);
            t_seg_out r;
            longint mx, mz, big, nx, nz, mm1, v1, v2, f, g, alpha;
            longint x1, z1, x2, z2;
            logic   invx, invz;
            r = '0;
            if (!(c.f_center > 0 && c.f_center < FRAC_ONE)) return r;
            r.mixed = 1'b1;
            mx = (longint'(c.f_sw) + 2 * longint'(c.f_w) + longint'(c.f_nw))
               - (longint'(c.f_se) + 2 * longint'(c.f_e) + longint'(c.f_ne));
            mz = (longint'(c.f_sw) + 2 * longint'(c.f_s) + longint'(c.f_se))
               - (longint'(c.f_nw) + 2 * longint'(c.f_n) + longint'(c.f_ne));
            invx = mx < 0;
            invz = mz < 0;
            if (invx) mx = -mx;
            if (invz) mz = -mz;
            big = (mx > mz) ? mx : mz;
            if (big == 0) begin
                nx = ONE_Q30;
                nz = ONE_Q30;
            end else begin
                nx = (mx << 30) / big;
                nz = (mz << 30) / big;
            end
            mm1 = (nx < nz) ? nx : nz;
            v1  = mm1 >>> 1;
            v2  = ONE_Q30 - v1;
            f   = longint'(c.f_center) << (30 - FRACTION_BITS);
            if (f < v1) begin
                // corner triangle
                alpha = root_floor(2 * f * mm1);
                x1 = sat_div(alpha, nx);
                z1 = 0;
                x2 = 0;
                z2 = sat_div(alpha, nz);
            end else if (f < v2) begin
                alpha = f + v1;
                if (nx > nz) begin
                    x1 = sat_div(alpha, nx);
                    x2 = sat_div(alpha - nz, nx);
                    z1 = 0;
                    z2 = ONE_Q30;
                end else begin
                    x1 = 0;
                    x2 = ONE_Q30;
                    z1 = sat_div(alpha, nz);
                    z2 = sat_div(alpha - nx, nz);
                end
            end else begin
                // complementary corner
                g = ONE_Q30 - f;
                if (g < 0) g = 0;
                alpha = root_floor(2 * g * mm1);
                x1 = ONE_Q30 - sat_div(alpha, nx);
                z1 = ONE_Q30;
                x2 = ONE_Q30;
                z2 = ONE_Q30 - sat_div(alpha, nz);
            end
            x1 = unit_clamp(x1);
            z1 = unit_clamp(z1);
            x2 = unit_clamp(x2);
            z2 = unit_clamp(z2);
            if (invx) begin
                x1 = ONE_Q30 - x1;
                x2 = ONE_Q30 - x2;
            end
            if (invz) begin
                z1 = ONE_Q30 - z1;
                z2 = ONE_Q30 - z2;
            end
            r.start_x = to_coord(longint'(c.origin_x), width_q16, x1);
            r.start_y = to_coord(longint'(c.origin_y), height_q16, z1);
            r.end_x   = to_coord(longint'(c.origin_x), width_q16, x2);
            r.end_y   = to_coord(longint'(c.origin_y), height_q16, z2);
            return r;
        endfunction

        function void note_request(t_cell_in c);
            pending.push_back(segment_of(c));
        endfunction

        function void check_result(t_seg_out got);
            t_seg_out exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.mixed !== exp.mixed) begin
                $display("%0t: mixed exp %0d got %0d", $time, exp.mixed, got.mixed);
                errors++;
            end
            if (got.start_x !== exp.start_x) begin
                $display("%0t: start_x exp %h got %h", $time, exp.start_x, got.start_x);
                errors++;
            end
            if (got.start_y !== exp.start_y) begin
                $display("%0t: start_y exp %h got %h", $time, exp.start_y, got.start_y);
                errors++;
            end
            if (got.end_x !== exp.end_x) begin
                $display("%0t: end_x exp %h got %h", $time, exp.end_x, got.end_x);
                errors++;
            end
            if (got.end_y !== exp.end_y) begin
                $display("%0t: end_y exp %h got %h", $time, exp.end_y, got.end_y);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cell_in    i_cell = '0;
    logic        o_done;
    t_seg_out    o_seg;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = REG_CELL_WIDTH;
    logic [30:0] i_cfg_data = '0;

    segment_scoreboard sb = new();
    int n_taken = 0;
    int n_done = 0;
    int idle_pct = 15;

    always #4 i_clk = ~i_clk;

    plic_interface_segment_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cell     (i_cell),
        .o_done     (o_done),
        .o_seg      (o_seg),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_seg);
            n_done++;
        end
    end

    // watchdog on cycles without any request or result
    int stall_cycles = 0;
    int last_progress = 0;
    always @(posedge i_clk) begin
        if (n_taken + n_done != last_progress) begin
            last_progress = n_taken + n_done;
            stall_cycles  = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles > STALL_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_request(t_cell_in c);
        start  <= 1'b1;
        i_cell <= c;
        do @(posedge i_clk); while (busy);
        sb.note_request(c);
        n_taken++;
    endtask

    task automatic maybe_idle();
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cell_reg idx, logic [30:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic drain_and_set(logic [30:0] w, logic [30:0] h);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(REG_CELL_WIDTH, w);
        write_reg(REG_CELL_HEIGHT, h);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(9, 0))
            0: return 16'd0;
            1: return 16'(FRAC_ONE);
            2: return 16'($urandom);  // full field width, out of range too
            default: return 16'($urandom_range(FRAC_ONE, 0));
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(7, 0))
            0: return 32'h7fff_0000 + $urandom_range(65535, 0);
            1: return 32'h8000_0000 + $urandom_range(65535, 0);
            2: return 32'($urandom_range(255, 0)) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cell_in make_cell(logic [15:0] sw, logic [15:0] w, logic [15:0] nw,
                                           logic [15:0] s, logic [15:0] ctr, logic [15:0] n,
                                           logic [15:0] se, logic [15:0] e, logic [15:0] ne,
                                           logic [31:0] ox, logic [31:0] oy);
        t_cell_in c;
        c.f_sw = sw; c.f_w = w; c.f_nw = nw;
        c.f_s = s; c.f_center = ctr; c.f_n = n;
        c.f_se = se; c.f_e = e; c.f_ne = ne;
        c.origin_x = ox; c.origin_y = oy;
        return c;
    endfunction

    function automatic t_cell_in random_cell();
        t_cell_in c;
        c.f_sw = rand_frac(); c.f_w = rand_frac(); c.f_nw = rand_frac();
        c.f_s = rand_frac(); c.f_n = rand_frac();
        c.f_se = rand_frac(); c.f_e = rand_frac(); c.f_ne = rand_frac();
        // mostly mixed cells so the geometry path is exercised
        if ($urandom_range(9, 0) < 8) begin
            c.f_center = 16'($urandom_range(FRAC_ONE - 1, 1));
        end else begin
            c.f_center = rand_frac();
        end
        c.origin_x = rand_origin();
        c.origin_y = rand_origin();
        return c;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            // no idling in the middle stretch
            idle_pct = (k > count / 3 && k < count / 2) ? 0 : 15;
            maybe_idle();
            send_request(random_cell());
        end
    endtask

    localparam logic [15:0] Z = 16'd0;
    localparam logic [15:0] F = 16'(FRAC_ONE);
    localparam logic [15:0] H = 16'(FRAC_ONE / 2);

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        drain_and_set(31'd65536, 31'd65536);
        // directed: uniform, empty, full, edge fractions, each line case, each fold
        send_request(make_cell(Z, Z, Z, Z, Z, Z, Z, Z, Z, 0, 0));
        send_request(make_cell(F, F, F, F, F, F, F, F, F, 0, 0));
        send_request(make_cell(H, H, H, H, H, H, H, H, H, 32'h0001_0000, 32'h0002_0000));
        send_request(make_cell(F, F, F, F, 16'd1, F, F, F, F, 0, 0));
        send_request(make_cell(Z, Z, Z, Z, 16'(FRAC_ONE - 1), Z, Z, Z, Z, 0, 0));
        send_request(make_cell(F, F, F, F, 16'hffff, F, F, F, F, 0, 0));
        send_request(make_cell(F, F, F, F, 16'd40000, Z, Z, Z, Z, 0, 0));
        send_request(make_cell(F, F, H, F, 16'd300, H, H, H, Z, 0, 0));
        send_request(make_cell(F, F, F, H, H, H, Z, Z, Z, 0, 0));
        send_request(make_cell(F, H, Z, F, H, Z, F, H, Z, 0, 0));
        send_request(make_cell(F, F, F, F, 16'(FRAC_ONE - 200), H, F, H, Z, 0, 0));
        send_request(make_cell(Z, Z, Z, H, H, H, F, F, F, 32'hffff_0000, 0));
        send_request(make_cell(Z, H, F, Z, H, F, Z, H, F, 0, 32'hfff0_0000));
        send_request(make_cell(Z, Z, H, Z, 16'd200, H, H, H, F, 32'h7fff_ffff,
                               32'h8000_0000));
        send_request(make_cell(F, F, F, F, H, F, F, F, F, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_cell(Z, F, Z, F, 16'd9000, Z, Z, Z, Z, 32'h7fff_8000,
                               32'h7fff_c000));
        random_phase(300);

        drain_and_set(31'd0, 31'h7fff_ffff);
        send_request(make_cell(F, F, H, F, H, Z, H, Z, Z, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_cell(Z, Z, H, Z, H, F, H, F, F, 32'h7fff_ffff, 32'h8000_0000));
        random_phase(150);

        drain_and_set(31'h7fff_ffff, 31'd0);
        random_phase(150);

        drain_and_set(31'($urandom_range(32'h0010_0000, 1)), 31'($urandom));
        random_phase(150);

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
